FILE: hw/rtl/irplt_pkg.sv
// irplt_pkg: shared types and constants for the ir pulse length transmitter
// register indexes, reset defaults, field widths and the phase encoding
// no dependencies
`default_nettype none

package irplt_pkg;

   // payload field widths
   localparam int DATA_W  = 8;
   localparam int ADDR_W  = 3;
   localparam int OP_W    = 1;

   // widest data / address field the frame builder supports
   localparam int DATA_EXT_W = 16;
   localparam int ADDR_EXT_W = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CNT8_W     = 8;
   localparam int CNT16_W    = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CARRIER_HALF = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PULSES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_PULSES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PULSES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER      = 3'd5;

   // register reset values
   localparam logic [CNT8_W-1:0]  RST_CARRIER_HALF = 8'd12;
   localparam logic [CNT8_W-1:0]  RST_START_PULSES = 8'd96;
   localparam logic [CNT8_W-1:0]  RST_ONE_PULSES   = 8'd48;
   localparam logic [CNT8_W-1:0]  RST_ZERO_PULSES  = 8'd24;
   localparam logic [CNT16_W-1:0] RST_GAP_TICKS    = 16'd600;
   localparam logic [CNT16_W-1:0] RST_TRAILER      = 16'd18000;

   // input op codes
   localparam logic [OP_W-1:0] OP_TICK = 1'b0;
   localparam logic [OP_W-1:0] OP_SEND = 1'b1;

   // transmitter phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_BURST   = 4'b0010,
      PH_GAP     = 4'b0100,
      PH_TRAILER = 4'b1000
   } phase_type;

   // configuration register set
   typedef struct packed {
      logic [CNT8_W-1:0]  carrier_half;
      logic [CNT8_W-1:0]  start_pulses;
      logic [CNT8_W-1:0]  one_pulses;
      logic [CNT8_W-1:0]  zero_pulses;
      logic [CNT16_W-1:0] gap_ticks;
      logic [CNT16_W-1:0] trailer_ticks;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ir_pulse_length_transmitter.sv
// ir_pulse_length_transmitter: pulse length coded infrared frame transmitter
// one tick word per microsecond, registered result word per input word
// depends on irplt_pkg
//
// result word: valid in the cycle after its input word is accepted
// throughput: one word per cycle while req_stall is low; each step is one pass
//   of logic between the state and result registers, so back to back ticks run
// reset: synchronous, active high; clears the phase, counters and the result
//   valid flag, and loads the register defaults (12, 96, 48, 24, 600, 18000)
`default_nettype none

module ir_pulse_length_transmitter
   import irplt_pkg::*;
#(
   parameter int DATA_BITS    = 8,
   parameter int ADDRESS_BITS = 3
) (
   input  wire                   clock,
   input  wire                   reset,

   // configuration write channel
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata,

   // input word channel
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire [OP_W-1:0]        req_op,
   input  wire [DATA_W-1:0]      req_data_byte,
   input  wire [ADDR_W-1:0]      req_device_address,

   // result word channel
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_led_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_send_refused,
   output logic                  rsp_frame_done
);

   // total frame bits and the width of the remaining bit count
   localparam int FRAME_W = DATA_BITS + ADDRESS_BITS;
   localparam int BITS_W  = $clog2(FRAME_W + 1);

   // ---------------------------------------------------------------
   // configuration registers, always ready
   // ---------------------------------------------------------------
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half  <= RST_CARRIER_HALF;
         cfg_ff.start_pulses  <= RST_START_PULSES;
         cfg_ff.one_pulses    <= RST_ONE_PULSES;
         cfg_ff.zero_pulses   <= RST_ZERO_PULSES;
         cfg_ff.gap_ticks     <= RST_GAP_TICKS;
         cfg_ff.trailer_ticks <= RST_TRAILER;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CARRIER_HALF: cfg_ff.carrier_half  <= csr_wdata[CNT8_W-1:0];
            CSR_START_PULSES: cfg_ff.start_pulses  <= csr_wdata[CNT8_W-1:0];
            CSR_ONE_PULSES:   cfg_ff.one_pulses    <= csr_wdata[CNT8_W-1:0];
            CSR_ZERO_PULSES:  cfg_ff.zero_pulses   <= csr_wdata[CNT8_W-1:0];
            CSR_GAP_TICKS:    cfg_ff.gap_ticks     <= csr_wdata;
            CSR_TRAILER:      cfg_ff.trailer_ticks <= csr_wdata;
            default: begin
               // indexes past the register list are dropped
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // handshake: a new word goes in whenever the result register is
   // empty or its word is being taken this cycle
   // ---------------------------------------------------------------
   logic accept;

   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // transmitter state
   // ---------------------------------------------------------------
   phase_type           phase_ff,        phase_in;
   logic                carrier_high_ff, carrier_high_in;
   logic [CNT8_W-1:0]   half_count_ff,   half_count_in;
   logic [CNT8_W-1:0]   pulses_left_ff,  pulses_left_in;
   logic [CNT16_W-1:0]  low_count_ff,    low_count_in;
   logic [FRAME_W-1:0]  frame_shift_ff,  frame_shift_in;
   logic [BITS_W-1:0]   bits_left_ff,    bits_left_in;

   // frame as loaded by a send word: data bits first, address above,
   // bits past either field width go out as zero
   logic [DATA_EXT_W-1:0] data_ext;
   logic [ADDR_EXT_W-1:0] addr_ext;
   logic [FRAME_W-1:0]    frame_load;

   assign data_ext = DATA_EXT_W'(req_data_byte);
   assign addr_ext = ADDR_EXT_W'(req_device_address);

   always_comb begin
      for (int i = 0; i < FRAME_W; i++) begin
         if (i < DATA_BITS) begin
            frame_load[i] = data_ext[i];
         end else begin
            frame_load[i] = addr_ext[i - DATA_BITS];
         end
      end
   end

   // incremented counters, wrapping at their width
   logic [CNT8_W-1:0]  half_inc;
   logic [CNT16_W-1:0] low_inc;

   assign half_inc = half_count_ff + 8'd1;
   assign low_inc  = low_count_ff + 16'd1;

   // burst launch shared by a send word and the end of a gap
   logic              start_burst;
   logic [CNT8_W-1:0] burst_count;

   // result fields of this step
   logic led_c, refused_c, done_c;

   always_comb begin
      phase_in        = phase_ff;
      carrier_high_in = carrier_high_ff;
      half_count_in   = half_count_ff;
      pulses_left_in  = pulses_left_ff;
      low_count_in    = low_count_ff;
      frame_shift_in  = frame_shift_ff;
      bits_left_in    = bits_left_ff;
      start_burst     = 1'b0;
      burst_count     = cfg_ff.start_pulses;
      led_c           = 1'b0;
      refused_c       = 1'b0;
      done_c          = 1'b0;

      if (req_op == OP_SEND) begin
         if (phase_ff != PH_IDLE) begin
            refused_c = 1'b1;
         end else begin
            frame_shift_in = frame_load;
            bits_left_in   = BITS_W'(FRAME_W);
            start_burst    = 1'b1;
            burst_count    = cfg_ff.start_pulses;
         end
      end else begin
         case (phase_ff)
            PH_BURST: begin
               led_c         = carrier_high_ff;
               half_count_in = half_inc;
               if (half_inc >= cfg_ff.carrier_half) begin
                  half_count_in = '0;
                  if (carrier_high_ff) begin
                     carrier_high_in = 1'b0;
                  end else begin
                     pulses_left_in = pulses_left_ff - 8'd1;
                     if (pulses_left_in == '0) begin
                        phase_in     = PH_GAP;
                        low_count_in = '0;
                     end else begin
                        carrier_high_in = 1'b1;
                     end
                  end
               end
            end
            PH_GAP: begin
               low_count_in = low_inc;
               if (low_inc >= cfg_ff.gap_ticks) begin
                  if (bits_left_ff != '0) begin
                     // next bit, least significant first
                     frame_shift_in = frame_shift_ff >> 1;
                     bits_left_in   = bits_left_ff - BITS_W'(1);
                     start_burst    = 1'b1;
                     burst_count    = frame_shift_ff[0] ? cfg_ff.one_pulses
                                                        : cfg_ff.zero_pulses;
                  end else begin
                     low_count_in = '0;
                     if (cfg_ff.trailer_ticks == '0) begin
                        phase_in = PH_IDLE;
                        done_c   = 1'b1;
                     end else begin
                        phase_in = PH_TRAILER;
                     end
                  end
               end
            end
            PH_TRAILER: begin
               low_count_in = low_inc;
               if (low_inc >= cfg_ff.trailer_ticks) begin
                  phase_in     = PH_IDLE;
                  low_count_in = '0;
                  done_c       = 1'b1;
               end
            end
            default: begin
               // idle tick: led low, nothing moves
            end
         endcase
      end

      // an empty burst drops straight into its gap
      if (start_burst) begin
         half_count_in  = '0;
         low_count_in   = '0;
         pulses_left_in = burst_count;
         if (burst_count == '0) begin
            carrier_high_in = 1'b0;
            phase_in        = PH_GAP;
         end else begin
            carrier_high_in = 1'b1;
            phase_in        = PH_BURST;
         end
      end

      // a send word reports the level the led now holds
      if (req_op == OP_SEND) begin
         led_c = (phase_in == PH_BURST) && carrier_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         carrier_high_ff <= 1'b0;
         half_count_ff   <= '0;
         pulses_left_ff  <= '0;
         low_count_ff    <= '0;
         frame_shift_ff  <= '0;
         bits_left_ff    <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         carrier_high_ff <= carrier_high_in;
         half_count_ff   <= half_count_in;
         pulses_left_ff  <= pulses_left_in;
         low_count_ff    <= low_count_in;
         frame_shift_ff  <= frame_shift_in;
         bits_left_ff    <= bits_left_in;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic led_ff, busy_ff, refused_ff, done_ff;

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_ff     <= led_c;
         busy_ff    <= (phase_in != PH_IDLE);
         refused_ff <= refused_c;
         done_ff    <= done_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_level    = led_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_send_refused = refused_ff;
   assign rsp_frame_done   = done_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------

   // a refused send only happens mid-frame
   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_refused |-> rsp_busy_res)
      else $error("send refused while idle");

   // the frame end word leaves the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res)
      else $error("frame done but still busy");

   // the led is never driven outside a frame
   a_led_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led_level |-> rsp_busy_res)
      else $error("led on while idle");

   // all frame bits are gone once the transmitter is idle
   a_idle_no_bits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> bits_left_ff == '0)
      else $error("idle with bits left to send");

   // a result register update follows every accepted word
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no result");

endmodule

`default_nettype wire
